// ===== rtl/core/plc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plc_pkg: shared types for the positional list store
// Command codes, cell update modes and the control word that is broadcast
// along the row of cells.
// ---------------------------------------------------------------------------
package plc_pkg;

    localparam int CMD_W = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_ERASE     = 3'd1,
        CMD_GET       = 3'd2,
        CMD_SET       = 3'd3,
        CMD_ADD_HEAD  = 3'd4,
        CMD_DROP_HEAD = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_ERASE  = 2'd2,
        MODE_WRITE  = 2'd3
    } mode_t;

    // Broadcast to every cell; pos_idx is the zero-based target position.
    typedef struct packed {
        mode_t              mode;
        logic [CNT_W-1:0]   pos_idx;
        logic [BYTE_W-1:0]  value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/plc_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plc_cell: one storage cell of the list
// Holds the element at zero-based position IDX and, under the broadcast
// control word, keeps it, takes its left or right neighbor, or loads a value.
// ---------------------------------------------------------------------------
module plc_cell #(
    parameter int IDX = 0
) (
    input  wire logic                        clk,
    input  wire plc_pkg::cell_ctrl_t         ctrl,
    input  wire logic [plc_pkg::BYTE_W-1:0]  left_data,
    input  wire logic [plc_pkg::BYTE_W-1:0]  right_data,
    output logic      [plc_pkg::BYTE_W-1:0]  data
);

    localparam logic [plc_pkg::CNT_W-1:0] MY_IDX = plc_pkg::CNT_W'(IDX);

    logic [plc_pkg::BYTE_W-1:0] data_reg;
    logic [plc_pkg::BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            plc_pkg::MODE_INSERT:
            begin
                // Cells behind the target move back by one.
                if (MY_IDX > ctrl.pos_idx)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == ctrl.pos_idx)
                begin
                    data_next = ctrl.value;
                end
            end
            plc_pkg::MODE_ERASE:
            begin
                if (MY_IDX >= ctrl.pos_idx)
                begin
                    data_next = right_data;
                end
            end
            plc_pkg::MODE_WRITE:
            begin
                if (MY_IDX == ctrl.pos_idx)
                begin
                    data_next = ctrl.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/positional_list_store_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_store_core: ordered byte list with positional access
// A row of DEPTH cells holds the list; insert and erase shift every cell
// behind the target together.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  command   start / busy         cmd, position, value
//  result    done (one cycle)     ok, read_value, count
//
// A command is taken at any edge where start is high; busy never rises, so
// one item can be issued every cycle. Its result is on the result ports
// during the following cycle with done high, and count reports the element
// count after that item. Reset empties the list; cell contents are not
// cleared. The receiver cannot stall, so nothing is buffered on the output.
// ---------------------------------------------------------------------------
module positional_list_store_core #(
    parameter int DEPTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [plc_pkg::CMD_W-1:0]   cmd,
    input  wire logic [7:0]                  position,
    input  wire logic [plc_pkg::BYTE_W-1:0]  value,
    output logic                             done,
    output logic                             ok,
    output logic      [plc_pkg::BYTE_W-1:0]  read_value,
    output logic      [plc_pkg::CNT_W-1:0]   count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [plc_pkg::CNT_W-1:0] DEPTH_C = plc_pkg::CNT_W'(DEPTH);

    logic [plc_pkg::CNT_W-1:0]  count_reg;
    logic [plc_pkg::CNT_W-1:0]  count_next;
    logic                       done_reg;
    logic                       ok_reg;
    logic                       ok_next;
    logic [plc_pkg::BYTE_W-1:0] rd_reg;
    logic [plc_pkg::BYTE_W-1:0] rd_next;

    plc_pkg::cell_ctrl_t        ctrl;
    logic [plc_pkg::BYTE_W-1:0] cell_data [DEPTH];

    logic                       pos_nz;
    logic                       pos_in_list;
    logic                       pos_in_gap;
    logic                       not_full;
    logic [plc_pkg::CNT_W-1:0]  pos_idx;
    logic [IW-1:0]              rd_idx;

    assign pos_nz      = (position != 8'd0);
    assign pos_in_list = pos_nz && (position <= count_reg);
    assign pos_in_gap  = pos_nz && ({1'b0, position} <= ({1'b0, count_reg} + 9'd1));
    assign not_full    = (count_reg < DEPTH_C);
    assign pos_idx     = position - 8'd1;
    assign rd_idx      = pos_idx[IW-1:0];

    // Command decode: validity, the broadcast cell control and the new count.
    always_comb
    begin
        ctrl.mode    = plc_pkg::MODE_HOLD;
        ctrl.pos_idx = pos_idx;
        ctrl.value   = value;
        ok_next      = 1'b0;
        rd_next      = '0;
        count_next   = count_reg;
        if (start)
        begin
            case (plc_pkg::cmd_t'(cmd))
                plc_pkg::CMD_INSERT:
                begin
                    if (not_full && pos_in_gap)
                    begin
                        ok_next    = 1'b1;
                        ctrl.mode  = plc_pkg::MODE_INSERT;
                        count_next = count_reg + 8'd1;
                    end
                end
                plc_pkg::CMD_ERASE:
                begin
                    if (pos_in_list)
                    begin
                        ok_next    = 1'b1;
                        ctrl.mode  = plc_pkg::MODE_ERASE;
                        count_next = count_reg - 8'd1;
                    end
                end
                plc_pkg::CMD_GET:
                begin
                    if (pos_in_list)
                    begin
                        ok_next = 1'b1;
                        rd_next = cell_data[rd_idx];
                    end
                end
                plc_pkg::CMD_SET:
                begin
                    if (pos_in_list)
                    begin
                        ok_next   = 1'b1;
                        ctrl.mode = plc_pkg::MODE_WRITE;
                    end
                end
                plc_pkg::CMD_ADD_HEAD:
                begin
                    ctrl.pos_idx = '0;
                    if (not_full)
                    begin
                        ok_next    = 1'b1;
                        ctrl.mode  = plc_pkg::MODE_INSERT;
                        count_next = count_reg + 8'd1;
                    end
                end
                plc_pkg::CMD_DROP_HEAD:
                begin
                    ctrl.pos_idx = '0;
                    if (count_reg != 8'd0)
                    begin
                        ok_next    = 1'b1;
                        ctrl.mode  = plc_pkg::MODE_ERASE;
                        count_next = count_reg - 8'd1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [plc_pkg::BYTE_W-1:0] left_d;
            logic [plc_pkg::BYTE_W-1:0] right_d;

            // The ends of the row see zero; the last cell loads it on an erase.
            if (k == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[k+1];
            end

            plc_cell #(
                .IDX (k)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        rd_reg <= rd_next;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign read_value = rd_reg;
    assign count      = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_reg <= DEPTH_C))
        else $error("element count exceeds list depth");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !ok_next) |=> (count_reg == $past(count_reg)))
        else $error("rejected item changed the element count");

    a_read_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (read_value != '0)) |-> ok)
        else $error("nonzero read value on a failed item");

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("accepted item produced no result");

endmodule
`default_nettype wire

// ===== tb/sv/positional_list_store_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_list_store_core_tb: self-checking bench for the list store
// Drives insert, erase, get, set, add-at-head and drop-head commands, plus the
// two unused command codes, against a behavioral copy of the list held here.
// Every reply is compared field by field with the reply predicted when its
// command was taken. Directed cases cover the empty and full list and the
// position limits; a long random run then grows and shrinks the list.
// ---------------------------------------------------------------------------
module positional_list_store_core_tb;

    localparam int LIST_DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_ITEMS = 352;

    // Codes the block does not define; they must be rejected.
    localparam logic [plc_pkg::CMD_W-1:0] CMD_RESERVED_A = 3'd6;
    localparam logic [plc_pkg::CMD_W-1:0] CMD_RESERVED_B = 3'd7;

    typedef struct {
        logic                       ok;
        logic [plc_pkg::BYTE_W-1:0] read_value;
        logic [plc_pkg::CNT_W-1:0]  count;
    } list_reply_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [plc_pkg::CMD_W-1:0]  cmd;
    logic [7:0]                 position;
    logic [plc_pkg::BYTE_W-1:0] value;
    logic                       done;
    logic                       ok;
    logic [plc_pkg::BYTE_W-1:0] read_value;
    logic [plc_pkg::CNT_W-1:0]  count;

    logic [plc_pkg::BYTE_W-1:0] list_cells [LIST_DEPTH];
    int                         list_len;
    list_reply_t                replies_due [$];
    int                         bad_replies;
    int                         idle_cycles;
    bit                         no_gaps;

    positional_list_store_core #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .position(position),
        .value(value),
        .done(done),
        .ok(ok),
        .read_value(read_value),
        .count(count)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral list
    // ------------------------------------------------------------------
    task automatic list_insert(input int pos, input logic [plc_pkg::BYTE_W-1:0] val,
                               output logic done_ok);
        begin
            done_ok = 1'b0;
            if (list_len < LIST_DEPTH && pos >= 1 && pos <= list_len + 1)
            begin
                for (int k = list_len; k >= pos; k--)
                begin
                    list_cells[k] = list_cells[k-1];
                end
                list_cells[pos-1] = val;
                list_len++;
                done_ok = 1'b1;
            end
        end
    endtask

    task automatic list_erase(input int pos, output logic done_ok);
        begin
            done_ok = 1'b0;
            if (pos >= 1 && pos <= list_len)
            begin
                for (int k = pos - 1; k + 1 < list_len; k++)
                begin
                    list_cells[k] = list_cells[k+1];
                end
                list_len--;
                done_ok = 1'b1;
            end
        end
    endtask

    task automatic apply_list_cmd(input logic [plc_pkg::CMD_W-1:0] op, input logic [7:0] pos,
                                  input logic [plc_pkg::BYTE_W-1:0] val,
                                  output list_reply_t reply);
        int p;
        begin
            p = int'(pos);
            reply.ok = 1'b0;
            reply.read_value = '0;
            case (op)
                plc_pkg::CMD_INSERT:    list_insert(p, val, reply.ok);
                plc_pkg::CMD_ERASE:     list_erase(p, reply.ok);
                plc_pkg::CMD_GET:
                begin
                    if (p >= 1 && p <= list_len)
                    begin
                        reply.read_value = list_cells[p-1];
                        reply.ok = 1'b1;
                    end
                end
                plc_pkg::CMD_SET:
                begin
                    if (p >= 1 && p <= list_len)
                    begin
                        list_cells[p-1] = val;
                        reply.ok = 1'b1;
                    end
                end
                plc_pkg::CMD_ADD_HEAD:  list_insert(1, val, reply.ok);
                plc_pkg::CMD_DROP_HEAD: list_erase(1, reply.ok);
                default:                reply.ok = 1'b0;
            endcase
            reply.count = plc_pkg::CNT_W'(list_len);
        end
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic issue_cmd(input logic [plc_pkg::CMD_W-1:0] op, input logic [7:0] pos,
                             input logic [plc_pkg::BYTE_W-1:0] val);
        list_reply_t reply;
        begin
            start <= 1'b1;
            cmd <= op;
            position <= pos;
            value <= val;
            @(posedge clk);
            while (busy)
            begin
                @(posedge clk);
            end
            apply_list_cmd(op, pos, val, reply);
            replies_due = {replies_due, reply};
        end
    endtask

    task automatic hold_off(input int cycles);
        begin
            if (cycles > 0)
            begin
                start <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
        end
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (no_gaps || r < 60)
                return 0;
            else if (r < 92)
                return $urandom_range(1, 3);
            else
                return $urandom_range(10, 40);
        end
    endfunction

    task automatic issue_then_gap(input logic [plc_pkg::CMD_W-1:0] op, input logic [7:0] pos,
                                  input logic [plc_pkg::BYTE_W-1:0] val);
        begin
            issue_cmd(op, pos, val);
            hold_off(pick_gap());
        end
    endtask

    task automatic wait_replies_drained();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (replies_due.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_and_limits();
        begin
            issue_then_gap(plc_pkg::CMD_DROP_HEAD, 8'd0, 8'h00);
            issue_then_gap(plc_pkg::CMD_ERASE, 8'd1, 8'h00);
            issue_then_gap(plc_pkg::CMD_GET, 8'd0, 8'h00);
            issue_then_gap(plc_pkg::CMD_GET, 8'd1, 8'h00);
            issue_then_gap(plc_pkg::CMD_SET, 8'd1, 8'hFF);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd0, 8'h11);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd2, 8'h22);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd1, 8'hFF);
            issue_then_gap(plc_pkg::CMD_ADD_HEAD, 8'd255, 8'h00);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd3, 8'h80);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd2, 8'h7F);
            for (int p = 1; p <= 5; p++)
            begin
                issue_then_gap(plc_pkg::CMD_GET, 8'(p), 8'hFF);
            end
            issue_then_gap(plc_pkg::CMD_SET, 8'd4, 8'h55);
            issue_then_gap(plc_pkg::CMD_GET, 8'd4, 8'h00);
            issue_then_gap(plc_pkg::CMD_SET, 8'd0, 8'hAA);
            issue_then_gap(plc_pkg::CMD_ERASE, 8'd255, 8'h00);
            issue_then_gap(plc_pkg::CMD_ERASE, 8'd0, 8'h00);
            issue_then_gap(CMD_RESERVED_A, 8'd1, 8'hFF);
            issue_then_gap(CMD_RESERVED_B, 8'd255, 8'hFF);
            issue_then_gap(plc_pkg::CMD_ERASE, 8'd2, 8'h00);
            issue_then_gap(plc_pkg::CMD_DROP_HEAD, 8'd0, 8'hFF);
            issue_then_gap(plc_pkg::CMD_GET, 8'd1, 8'h00);
        end
    endtask

    task automatic test_full_list();
        begin
            while (list_len < LIST_DEPTH)
            begin
                issue_then_gap(plc_pkg::CMD_INSERT, 8'($urandom_range(1, list_len + 1)),
                               8'($urandom_range(0, 255)));
            end
            issue_then_gap(plc_pkg::CMD_ADD_HEAD, 8'd1, 8'h5A);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'd1, 8'hA5);
            issue_then_gap(plc_pkg::CMD_INSERT, 8'(LIST_DEPTH + 1), 8'hA5);
            issue_then_gap(plc_pkg::CMD_GET, 8'(LIST_DEPTH), 8'h00);
            issue_then_gap(plc_pkg::CMD_SET, 8'(LIST_DEPTH), 8'hC3);
            issue_then_gap(plc_pkg::CMD_GET, 8'(LIST_DEPTH), 8'h00);
            issue_then_gap(plc_pkg::CMD_GET, 8'(LIST_DEPTH + 1), 8'h00);
            wait_replies_drained();
            while (list_len > 0)
            begin
                issue_then_gap(plc_pkg::CMD_ERASE, 8'($urandom_range(1, list_len)), 8'h00);
            end
            issue_then_gap(plc_pkg::CMD_DROP_HEAD, 8'd1, 8'h00);
        end
    endtask

    task automatic test_random_traffic();
        logic [plc_pkg::CMD_W-1:0] op;
        logic [7:0]                pos;
        bit                        growing;
        int                        r;
        int                        w;
        begin
            growing = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if (n == RANDOM_ITEMS / 2)
                    wait_replies_drained();
                // Swing the list between empty and full so both ends get hit often.
                if (list_len == LIST_DEPTH)
                    growing = 1'b0;
                else if (list_len == 0)
                    growing = 1'b1;
                else if ($urandom_range(0, 39) == 0)
                    growing = !growing;

                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    op = plc_pkg::CMD_W'($urandom_range(0, 7));
                    pos = 8'($urandom_range(0, 255));
                end
                else
                begin
                    w = $urandom_range(0, 99);
                    if (w < (growing ? 35 : 10))
                        op = plc_pkg::CMD_INSERT;
                    else if (w < 50)
                        op = growing ? plc_pkg::CMD_ADD_HEAD : plc_pkg::CMD_ERASE;
                    else if (w < 65)
                        op = growing ? plc_pkg::CMD_ERASE : plc_pkg::CMD_DROP_HEAD;
                    else if (w < 70)
                        op = growing ? plc_pkg::CMD_DROP_HEAD : plc_pkg::CMD_ADD_HEAD;
                    else if (w < 85)
                        op = plc_pkg::CMD_GET;
                    else
                        op = plc_pkg::CMD_SET;
                    if (r < 10)
                    begin
                        case ($urandom_range(0, 2))
                            0:       pos = 8'd0;
                            1:       pos = 8'(list_len + 1);
                            default: pos = 8'(list_len + 2);
                        endcase
                    end
                    else if (op == plc_pkg::CMD_INSERT)
                        pos = 8'($urandom_range(1, list_len + 1));
                    else
                        pos = 8'($urandom_range(1, (list_len > 0) ? list_len : 1));
                end
                issue_then_gap(op, pos, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Reply checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding: ok=%0b read_value=%02h count=%0d",
                         $time, ok, read_value, count);
                bad_replies++;
            end
            else
            begin
                want = replies_due[0];
                replies_due.delete(0);
                if (ok !== want.ok)
                begin
                    $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, ok);
                    bad_replies++;
                end
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %02h, actual %02h",
                             $time, want.read_value, read_value);
                    bad_replies++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, want.count, count);
                    bad_replies++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = plc_pkg::CMD_INSERT;
        position = '0;
        value = '0;
        list_len = 0;
        bad_replies = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_limits();
        test_full_list();
        test_random_traffic();

        wait_replies_drained();
        repeat (4) @(posedge clk);
        if (bad_replies == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
